[hw/rtl/ledfade_pkg.sv]
package ledfade_pkg;

   // Widths fixed by the item and register fields
   localparam int LEVEL_W  = 10;
   localparam int PCT_W    = 7;
   localparam int FADE_W   = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;

   // Block constants
   localparam int PWM_RANGE      = 1023;
   localparam int TICK_PERIOD_MS = 10;
   localparam int PCT_FULL       = 100;
   localparam int FADE_MAX       = PWM_RANGE * TICK_PERIOD_MS;

   // On target level at reset: full brightness
   localparam int TARGET_RESET   = PWM_RANGE * PCT_FULL / PCT_FULL;

   // Divide-by-100 reciprocal 5243 / 2^19 folded with PWM_RANGE: exact floor for
   // pct*PWM_RANGE up to 102300
   localparam int TARGET_RECIP_W = 23;
   localparam int TARGET_SHIFT   = 19;
   localparam logic [TARGET_RECIP_W-1:0] TARGET_RECIP = TARGET_RECIP_W'(PWM_RANGE * 5243);

   // Divide-by-10 reciprocal 52429 / 2^19: exact floor over the full 16-bit range
   localparam int TICK_RECIP_W = 16;
   localparam int TICK_SHIFT   = 19;
   localparam logic [TICK_RECIP_W-1:0] TICK_RECIP = 16'd52429;

   localparam int DIV_CNT_W = $clog2(LEVEL_W + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BRIGHTNESS = 1'b0,
      CSR_FADE_TIME  = 1'b1
   } csr_index_type;

   typedef enum logic {
      OP_TICK    = 1'b0,
      OP_REQUEST = 1'b1
   } op_type;

   // Step divider status toward the top level
   typedef struct packed {
      logic               busy;
      logic               done;
      logic [LEVEL_W-1:0] quotient;
   } div_rsp_type;

endpackage

[hw/rtl/ledfade_req_if.sv]
interface ledfade_req_if;
   logic valid;
   logic ready;
   logic op;
   logic want_on;
   logic fast;

   modport source (output valid, output op, output want_on, output fast, input ready);
   modport sink   (input valid, input op, input want_on, input fast, output ready);
endinterface

[hw/rtl/ledfade_rsp_if.sv]
interface ledfade_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [ledfade_pkg::LEVEL_W-1:0]  pwm_level;
   logic                             is_on;
   logic                             ramping;

   modport source (output valid, output pwm_level, output is_on, output ramping, input ready);
   modport sink   (input valid, input pwm_level, input is_on, input ramping, output ready);
endinterface

[hw/rtl/ledfade_csr_if.sv]
interface ledfade_csr_if;
   logic                               valid;
   logic                               ready;
   logic [ledfade_pkg::CSR_IDX_W-1:0]  index;
   logic [ledfade_pkg::CSR_DAT_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/ledfade_div.sv]
// Restoring divider: PWM_RANGE / divisor, one quotient bit per cycle
module ledfade_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [ledfade_pkg::LEVEL_W-1:0]  divisor,
   output ledfade_pkg::div_rsp_type         status
);

   logic [ledfade_pkg::DIV_CNT_W-1:0] count_ff, count_in;
   logic [ledfade_pkg::LEVEL_W-1:0]   rem_ff, rem_in;
   logic [ledfade_pkg::LEVEL_W-1:0]   num_ff, num_in;
   logic [ledfade_pkg::LEVEL_W-1:0]   dvs_ff, dvs_in;
   logic                              done_ff, done_in;
   logic [ledfade_pkg::LEVEL_W:0]     trial;
   logic [ledfade_pkg::LEVEL_W:0]     diff;

   // One shift-subtract step
   always_comb begin
      trial    = {rem_ff, num_ff[ledfade_pkg::LEVEL_W-1]};
      diff     = trial - {1'b0, dvs_ff};
      count_in = count_ff;
      rem_in   = rem_ff;
      num_in   = num_ff;
      dvs_in   = dvs_ff;
      done_in  = 1'b0;
      if (start) begin
         count_in = ledfade_pkg::DIV_CNT_W'(ledfade_pkg::LEVEL_W);
         rem_in   = '0;
         num_in   = ledfade_pkg::LEVEL_W'(ledfade_pkg::PWM_RANGE);
         dvs_in   = divisor;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         if (!diff[ledfade_pkg::LEVEL_W]) begin
            rem_in = diff[ledfade_pkg::LEVEL_W-1:0];
            num_in = {num_ff[ledfade_pkg::LEVEL_W-2:0], 1'b1};
         end else begin
            rem_in = trial[ledfade_pkg::LEVEL_W-1:0];
            num_in = {num_ff[ledfade_pkg::LEVEL_W-2:0], 1'b0};
         end
         done_in = (count_ff == ledfade_pkg::DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      dvs_ff <= dvs_in;
   end

   assign status.busy     = (count_ff != '0);
   assign status.done     = done_ff;
   assign status.quotient = num_ff;

endmodule

[hw/rtl/led_on_off_fade_ramp.sv]
// On/off fader for a PWM-driven LED string. Each req transaction (a tick or an
// on/off request) yields exactly one rsp transaction carrying the PWM level, the
// on status and the ramping flag, through an input register and a result
// register; one transaction is accepted per cycle unless rsp stalls or the step
// divider runs. A brightness write sets the target level. A CSR write of a valid
// nonzero fade time starts the step divider (PWM range over fade ticks, one
// quotient bit a cycle): req and csr stay not-ready while it runs. Brightness
// above 100 in the low seven bits and out-of-range nonzero fade times are ignored.
module led_on_off_fade_ramp (
   input  logic          clock,
   input  logic          reset,
   ledfade_req_if.sink   req,
   ledfade_rsp_if.source rsp,
   ledfade_csr_if.sink   csr
);

   localparam int LW = ledfade_pkg::LEVEL_W;

   // Fader state
   logic [LW-1:0] level_now_ff, level_now_in;
   logic [LW-1:0] target_level_ff;
   logic [LW-1:0] step_size_ff;
   logic          on_now_ff, on_now_in;
   logic          on_wanted_ff, on_wanted_in;
   logic          fading_ff, fading_in;
   logic          fade_zero_ff;

   // Input register
   logic          in_valid_ff;
   logic          in_op_ff, in_want_ff, in_fast_ff;

   // Result register
   logic          out_valid_ff;
   logic [LW-1:0] out_level_ff;
   logic          out_on_ff, out_ramp_ff;

   // Configuration path
   logic                                   start_ff;
   logic [LW-1:0]                          ticks_ff;
   logic                                   cfg_busy;
   logic                                   csr_fire;
   logic                                   brt_write, fade_write;
   logic [ledfade_pkg::PCT_W-1:0]          pct;
   logic [ledfade_pkg::FADE_W-1:0]         fade_t;
   logic                                   fade_ok;
   logic [ledfade_pkg::PCT_W+ledfade_pkg::TARGET_RECIP_W-1:0] target_prod;
   logic [2*ledfade_pkg::FADE_W-1:0]       ticks_prod;
   ledfade_pkg::div_rsp_type               div_status;

   logic          advance;
   logic          req_fire;
   logic [LW:0]   level_up;

   ledfade_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (start_ff),
      .divisor (ticks_ff),
      .status  (div_status)
   );

   assign cfg_busy  = start_ff | div_status.busy;
   assign csr.ready = ~cfg_busy;
   assign csr_fire  = csr.valid & csr.ready;

   // CSR decode and range checks
   always_comb begin
      brt_write  = 1'b0;
      fade_write = 1'b0;
      unique case (ledfade_pkg::csr_index_type'(csr.index))
         ledfade_pkg::CSR_BRIGHTNESS: brt_write  = csr_fire;
         ledfade_pkg::CSR_FADE_TIME:  fade_write = csr_fire;
         default: begin
            brt_write  = 1'b0;
            fade_write = 1'b0;
         end
      endcase
   end

   assign pct         = csr.data[ledfade_pkg::PCT_W-1:0];
   assign fade_t      = csr.data[ledfade_pkg::FADE_W-1:0];
   assign fade_ok     = (fade_t >= ledfade_pkg::FADE_W'(ledfade_pkg::TICK_PERIOD_MS)) &&
                        (fade_t <= ledfade_pkg::FADE_W'(ledfade_pkg::FADE_MAX));
   assign target_prod = {{ledfade_pkg::TARGET_RECIP_W{1'b0}}, pct} *
                        {{ledfade_pkg::PCT_W{1'b0}}, ledfade_pkg::TARGET_RECIP};
   assign ticks_prod  = {{ledfade_pkg::FADE_W{1'b0}}, fade_t} *
                        {{ledfade_pkg::FADE_W{1'b0}}, ledfade_pkg::TICK_RECIP};

   always_ff @(posedge clock) begin
      if (reset) begin
         target_level_ff <= LW'(ledfade_pkg::TARGET_RESET);
         step_size_ff    <= '0;
         fade_zero_ff    <= 1'b1;
         start_ff        <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         if (brt_write && (pct <= ledfade_pkg::PCT_W'(ledfade_pkg::PCT_FULL))) begin
            target_level_ff <= target_prod[ledfade_pkg::TARGET_SHIFT +: LW];
         end
         if (fade_write && (fade_t == '0)) begin
            fade_zero_ff <= 1'b1;
         end else if (fade_write && fade_ok) begin
            fade_zero_ff <= 1'b0;
            start_ff     <= 1'b1;
         end
         if (div_status.done) begin
            step_size_ff <= div_status.quotient;
         end
      end
   end

   // Tick count of a fade, registered ahead of the divider
   always_ff @(posedge clock) begin
      if (fade_write && fade_ok) begin
         ticks_ff <= ticks_prod[ledfade_pkg::TICK_SHIFT +: LW];
      end
   end

   // Handshake: input register feeds result register
   assign advance   = in_valid_ff & (~out_valid_ff | rsp.ready);
   assign req.ready = (~in_valid_ff | advance) & ~cfg_busy;
   assign req_fire  = req.valid & req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_fire) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
      if (req_fire) begin
         in_op_ff   <= req.op;
         in_want_ff <= req.want_on;
         in_fast_ff <= req.fast;
      end
   end

   // Next fader state for the item in the input register
   assign level_up = {1'b0, level_now_ff} + {1'b0, step_size_ff};

   always_comb begin
      level_now_in = level_now_ff;
      on_now_in    = on_now_ff;
      on_wanted_in = on_wanted_ff;
      fading_in    = fading_ff;
      case (ledfade_pkg::op_type'(in_op_ff))
         ledfade_pkg::OP_TICK: begin
            if (on_now_ff != on_wanted_ff) begin
               if (fade_zero_ff) begin
                  level_now_in = on_wanted_ff ? target_level_ff : '0;
                  on_now_in    = on_wanted_ff;
               end else if (!on_wanted_ff) begin
                  if (level_now_ff > step_size_ff) begin
                     level_now_in = level_now_ff - step_size_ff;
                     fading_in    = 1'b1;
                  end else begin
                     level_now_in = '0;
                     on_now_in    = 1'b0;
                     fading_in    = 1'b0;
                  end
               end else begin
                  if (level_up < {1'b0, target_level_ff}) begin
                     level_now_in = level_up[LW-1:0];
                     fading_in    = 1'b1;
                  end else begin
                     level_now_in = target_level_ff;
                     on_now_in    = 1'b1;
                     fading_in    = 1'b0;
                  end
               end
            end
         end
         ledfade_pkg::OP_REQUEST: begin
            // fast request jumps to the end; a plain one only records the wish
            if (in_fast_ff) begin
               level_now_in = in_want_ff ? target_level_ff : '0;
               on_now_in    = in_want_ff;
               fading_in    = 1'b0;
            end
            on_wanted_in = in_want_ff;
         end
         default: begin
            level_now_in = level_now_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_now_ff <= '0;
         on_now_ff    <= 1'b0;
         on_wanted_ff <= 1'b0;
         fading_ff    <= 1'b0;
      end else if (advance) begin
         level_now_ff <= level_now_in;
         on_now_ff    <= on_now_in;
         on_wanted_ff <= on_wanted_in;
         fading_ff    <= fading_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_level_ff <= level_now_in;
         out_on_ff    <= on_now_in;
         out_ramp_ff  <= fading_in;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.pwm_level = out_level_ff;
   assign rsp.is_on     = out_on_ff;
   assign rsp.ramping   = out_ramp_ff;

   // Checks
   a_fade_starts_div: assert property (@(posedge clock) disable iff (reset)
      (fade_write && fade_ok) |=> cfg_busy)
      else $error("valid fade time write did not start the step divider");

   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      cfg_busy |-> (!req.ready && !csr.ready))
      else $error("transaction accepted while step divider runs");

   a_advance_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp.valid && rsp.pwm_level == level_now_ff && rsp.is_on == on_now_ff))
      else $error("result register does not match fader state");

endmodule

[verif/tb_led_on_off_fade_ramp.sv]
`timescale 1ns / 1ps

module tb_led_on_off_fade_ramp;
   import ledfade_pkg::*;

   typedef struct packed {
      logic [LEVEL_W-1:0] pwm_level;
      logic               is_on;
      logic               ramping;
   } fade_result_type;

   // Expected value typed into a directed row; known = 0 defers to the fader model
   typedef struct packed {
      logic            known;
      fade_result_type res;
   } fade_check_type;

   typedef enum logic {
      ROW_WRITE = 1'b0,
      ROW_ITEM  = 1'b1
   } row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      csr_index_type          idx;
      logic [CSR_DAT_W-1:0]   data;
      op_type                 op;
      logic                   want_on;
      logic                   fast;
      fade_check_type         chk;
   } dir_row_type;

   localparam fade_check_type PRED = '0;
   localparam int DIR_ROWS = 36;
   localparam int PHASES = 9;
   localparam int PHASE_ITEMS = 50;

   // Directed sequence: reset state, target change while on, ignored writes,
   // fastest and slowest ramps, fading switched off mid-ramp
   localparam dir_row_type DIR_TAB [DIR_ROWS] = '{
      '{ROW_ITEM,  CSR_BRIGHTNESS, 16'd0,     OP_TICK,    1'b0, 1'b0, '{1'b1, '{10'd0, 1'b0, 1'b0}}},
      '{ROW_ITEM,  CSR_BRIGHTNESS, 16'd0,     OP_REQUEST, 1'b1, 1'b0, '{1'b1, '{10'd0, 1'b0, 1'b0}}},
      '{ROW_ITEM,  CSR_BRIGHTNESS, 16'd0,     OP_TICK,    1'b0, 1'b0,
        '{1'b1, '{10'd1023, 1'b1, 1'b0}}},
      '{ROW_ITEM,  CSR_BRIGHTNESS, 16'd0,     OP_REQUEST, 1'b1, 1'b0,
        '{1'b1, '{10'd1023, 1'b1, 1'b0}}},
      '{ROW_WRITE, CSR_BRIGHTNESS, 16'd0,     OP_TICK,    1'b0, 1'b0, PRED},
      '{ROW_ITEM,  CSR_BRIGHTNESS, 16'd0,     OP_TICK,    1'b0, 1'b0,
        '{1'b1, '{10'd1023, 1'b1, 1'b0}}},
      '{ROW_ITEM,  CSR_BRIGHTNESS, 16'd0,     OP_REQUEST, 1'b0, 1'b1, '{1'b1, '{10'd0, 1'b0, 1'b0}}},
      '{ROW_ITEM,  CSR_BRIGHTNESS, 16'd0,     OP_REQUEST, 1'b1, 1'b1, '{1'b1, '{10'd0, 1'b1, 1'b0}}},
      '{ROW_WRITE, CSR_BRIGHTNESS, 16'd127,   OP_TICK,    1'b0, 1'b0, PRED},
      '{ROW_ITEM,  CSR_BRIGHTNESS, 16'd0,     OP_REQUEST, 1'b1, 1'b1, '{1'b1, '{10'd0, 1'b1, 1'b0}}},
      '{ROW_WRITE, CSR_BRIGHTNESS, 16'hFFE4,  OP_TICK,    1'b0, 1'b0, PRED},
      '{ROW_ITEM,  CSR_BRIGHTNESS, 16'd0,     OP_REQUEST, 1'b1, 1'b1, PRED},
      '{ROW_WRITE, CSR_FADE_TIME,  16'd9,     OP_TICK,    1'b0, 1'b0, PRED},
      '{ROW_WRITE, CSR_FADE_TIME,  16'd10231, OP_TICK,    1'b0, 1'b0, PRED},
      '{ROW_ITEM,  CSR_BRIGHTNESS, 16'd0,     OP_REQUEST, 1'b0, 1'b0, PRED},
      '{ROW_ITEM,  CSR_BRIGHTNESS, 16'd0,     OP_TICK,    1'b0, 1'b0, '{1'b1, '{10'd0, 1'b0, 1'b0}}},
      '{ROW_WRITE, CSR_FADE_TIME,  16'd10,    OP_TICK,    1'b0, 1'b0, PRED},
      '{ROW_ITEM,  CSR_BRIGHTNESS, 16'd0,     OP_REQUEST, 1'b1, 1'b0, PRED},
      '{ROW_ITEM,  CSR_BRIGHTNESS, 16'd0,     OP_TICK,    1'b0, 1'b0, PRED},
      '{ROW_WRITE, CSR_FADE_TIME,  16'd10230, OP_TICK,    1'b0, 1'b0, PRED},
      '{ROW_ITEM,  CSR_BRIGHTNESS, 16'd0,     OP_REQUEST, 1'b0, 1'b0, PRED},
      '{ROW_ITEM,  CSR_BRIGHTNESS, 16'd0,     OP_TICK,    1'b0, 1'b0, PRED},
      '{ROW_ITEM,  CSR_BRIGHTNESS, 16'd0,     OP_TICK,    1'b0, 1'b0, PRED},
      '{ROW_WRITE, CSR_FADE_TIME,  16'd0,     OP_TICK,    1'b0, 1'b0, PRED},
      '{ROW_ITEM,  CSR_BRIGHTNESS, 16'd0,     OP_TICK,    1'b0, 1'b0, PRED},
      '{ROW_ITEM,  CSR_BRIGHTNESS, 16'd0,     OP_TICK,    1'b0, 1'b0, PRED},
      '{ROW_ITEM,  CSR_BRIGHTNESS, 16'd0,     OP_REQUEST, 1'b0, 1'b1, '{1'b1, '{10'd0, 1'b0, 1'b0}}},
      '{ROW_WRITE, CSR_BRIGHTNESS, 16'd50,    OP_TICK,    1'b0, 1'b0, PRED},
      '{ROW_WRITE, CSR_FADE_TIME,  16'hFFFF,  OP_TICK,    1'b0, 1'b0, PRED},
      '{ROW_WRITE, CSR_FADE_TIME,  16'd40,    OP_TICK,    1'b0, 1'b0, PRED},
      '{ROW_ITEM,  CSR_BRIGHTNESS, 16'd0,     OP_REQUEST, 1'b1, 1'b0, PRED},
      '{ROW_ITEM,  CSR_BRIGHTNESS, 16'd0,     OP_TICK,    1'b0, 1'b0, PRED},
      '{ROW_ITEM,  CSR_BRIGHTNESS, 16'd0,     OP_TICK,    1'b0, 1'b0, PRED},
      '{ROW_ITEM,  CSR_BRIGHTNESS, 16'd0,     OP_TICK,    1'b0, 1'b0, PRED},
      '{ROW_ITEM,  CSR_BRIGHTNESS, 16'd0,     OP_REQUEST, 1'b0, 1'b0, PRED},
      '{ROW_ITEM,  CSR_BRIGHTNESS, 16'd0,     OP_TICK,    1'b0, 1'b0, PRED}
   };

   logic clock;
   logic reset;
   bit   calm;
   int   stall_left;
   int   err_count;

   ledfade_req_if req_if ();
   ledfade_rsp_if rsp_if ();
   ledfade_csr_if csr_if ();

   led_on_off_fade_ramp DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   // Fader model state
   logic [PCT_W-1:0]   fdr_bright;
   logic [FADE_W-1:0]  fdr_fade;
   logic [LEVEL_W-1:0] fdr_level;
   logic [LEVEL_W-1:0] fdr_target;
   logic [LEVEL_W-1:0] fdr_step;
   logic               fdr_on;
   logic               fdr_want;
   logic               fdr_fading;

   fade_check_type  typed_checks [$];
   fade_result_type pending_levels [$];

   always #2 clock = ~clock;

   function automatic logic [LEVEL_W-1:0] pct_to_pwm(int unsigned pct);
      return LEVEL_W'(pct * PWM_RANGE / PCT_FULL);
   endfunction

   function void fader_reset();
      fdr_bright = PCT_W'(PCT_FULL);
      fdr_fade   = '0;
      fdr_level  = '0;
      fdr_target = pct_to_pwm(PCT_FULL);
      fdr_step   = '0;
      fdr_on     = 1'b0;
      fdr_want   = 1'b0;
      fdr_fading = 1'b0;
   endfunction

   // Register write: out-of-range values leave register and derived value alone
   function void fader_write_reg(csr_index_type idx, logic [CSR_DAT_W-1:0] val);
      int unsigned t;
      t = 32'(val);
      case (idx)
         CSR_BRIGHTNESS: begin
            if (val[PCT_W-1:0] <= PCT_FULL) begin
               fdr_bright = val[PCT_W-1:0];
               fdr_target = pct_to_pwm(val[PCT_W-1:0]);
            end
         end
         CSR_FADE_TIME: begin
            if (t == 0) begin
               fdr_fade = '0;
            end else if (t >= TICK_PERIOD_MS && t <= FADE_MAX) begin
               fdr_fade = val;
               fdr_step = LEVEL_W'(PWM_RANGE / (t / TICK_PERIOD_MS));
            end
         end
      endcase
   endfunction

   function fade_result_type fader_advance(op_type op, logic want, logic fast);
      if (op == OP_TICK) begin
         if (fdr_on != fdr_want) begin
            if (fdr_fade == 0) begin
               // no fading: jump to the wanted end, fading flag untouched
               fdr_level = fdr_want ? fdr_target : '0;
               fdr_on    = fdr_want;
            end else if (!fdr_want) begin
               if (fdr_level > fdr_step) begin
                  fdr_level  = fdr_level - fdr_step;
                  fdr_fading = 1'b1;
               end else begin
                  fdr_on     = 1'b0;
                  fdr_level  = '0;
                  fdr_fading = 1'b0;
               end
            end else begin
               if ({1'b0, fdr_level} + {1'b0, fdr_step} < {1'b0, fdr_target}) begin
                  fdr_level  = fdr_level + fdr_step;
                  fdr_fading = 1'b1;
               end else begin
                  fdr_on     = 1'b1;
                  fdr_level  = fdr_target;
                  fdr_fading = 1'b0;
               end
            end
         end
      end else if (want != fdr_want || fast) begin
         if (fast) begin
            fdr_level  = want ? fdr_target : '0;
            fdr_on     = want;
            fdr_fading = 1'b0;
         end
         fdr_want = want;
      end
      return '{fdr_level, fdr_on, fdr_fading};
   endfunction

   // Result channel stalls in random bursts
   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_if.ready <= 1'b1;
         stall_left   <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (rsp_if.ready && $urandom_range(0, 3) == 0) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= $urandom_range(0, 11);
      end else begin
         rsp_if.ready <= 1'b1;
         stall_left   <= $urandom_range(0, 19);
      end
   end

   // Monitor: register writes, accepted transactions, result check
   always @(posedge clock) begin
      fade_check_type  chk;
      fade_result_type pred;
      fade_result_type exp_res;
      if (!reset) begin
         if (csr_if.valid && csr_if.ready)
            fader_write_reg(csr_index_type'(csr_if.index), csr_if.data);
         if (req_if.valid && req_if.ready) begin
            chk = PRED;
            if (typed_checks.size() != 0)
               chk = typed_checks.pop_front();
            pred = fader_advance(op_type'(req_if.op), req_if.want_on, req_if.fast);
            pending_levels.push_back(chk.known ? chk.res : pred);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_levels.size() == 0) begin
               $display("%0t: unexpected rsp transaction, pwm_level %0d is_on %0b ramping %0b",
                        $time, rsp_if.pwm_level, rsp_if.is_on, rsp_if.ramping);
               err_count++;
            end else begin
               exp_res = pending_levels.pop_front();
               if (rsp_if.pwm_level !== exp_res.pwm_level) begin
                  $display("%0t: pwm_level mismatch, expected %0d, actual %0d",
                           $time, exp_res.pwm_level, rsp_if.pwm_level);
                  err_count++;
               end
               if (rsp_if.is_on !== exp_res.is_on) begin
                  $display("%0t: is_on mismatch, expected %0b, actual %0b",
                           $time, exp_res.is_on, rsp_if.is_on);
                  err_count++;
               end
               if (rsp_if.ramping !== exp_res.ramping) begin
                  $display("%0t: ramping mismatch, expected %0b, actual %0b",
                           $time, exp_res.ramping, rsp_if.ramping);
                  err_count++;
               end
            end
         end
      end
   end

   // One req transaction, with an optional idle burst ahead of it
   task automatic send_item(op_type op, logic want, logic fast, fade_check_type chk);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 4) == 0)
         gap = $urandom_range(1, 12);
      @(negedge clock);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.op      <= op;
      req_if.want_on <= want;
      req_if.fast    <= fast;
      typed_checks.push_back(chk);
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Drain all results, then let the pipeline go quiet before a register write
   task automatic settle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_levels.size() != 0 || typed_checks.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DAT_W-1:0] val);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   function automatic logic [CSR_DAT_W-1:0] pick_brightness();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return CSR_DAT_W'(PCT_FULL);
         2:       return CSR_DAT_W'($urandom_range(PCT_FULL + 1, 127));
         3:       return CSR_DAT_W'($urandom);
         default: return CSR_DAT_W'($urandom_range(0, PCT_FULL));
      endcase
   endfunction

   // Mostly short fades so ramps finish inside a phase
   function automatic logic [CSR_DAT_W-1:0] pick_fade_time();
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return CSR_DAT_W'(TICK_PERIOD_MS);
         2:       return CSR_DAT_W'(FADE_MAX);
         3:       return CSR_DAT_W'($urandom_range(1, TICK_PERIOD_MS - 1));
         4:       return CSR_DAT_W'($urandom_range(FADE_MAX + 1, 65535));
         5:       return CSR_DAT_W'($urandom_range(TICK_PERIOD_MS, 200));
         default: return CSR_DAT_W'($urandom_range(20, 600));
      endcase
   endfunction

   initial begin
      logic want;
      logic fast;
      clock          = 1'b0;
      reset          = 1'b1;
      calm           = 1'b0;
      err_count      = 0;
      req_if.valid   = 1'b0;
      req_if.op      = OP_TICK;
      req_if.want_on = 1'b0;
      req_if.fast    = 1'b0;
      csr_if.valid   = 1'b0;
      csr_if.index   = CSR_BRIGHTNESS;
      csr_if.data    = '0;
      fader_reset();
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Directed table
      foreach (DIR_TAB[i]) begin
         if (DIR_TAB[i].kind == ROW_WRITE) begin
            settle();
            write_reg(DIR_TAB[i].idx, DIR_TAB[i].data);
         end else begin
            send_item(DIR_TAB[i].op, DIR_TAB[i].want_on, DIR_TAB[i].fast, DIR_TAB[i].chk);
         end
      end

      // Random phases, new register settings between them; last phase without idling
      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         calm = (ph == PHASES - 1);
         if ($urandom_range(0, 1) == 0) begin
            write_reg(CSR_BRIGHTNESS, pick_brightness());
            write_reg(CSR_FADE_TIME, pick_fade_time());
         end else begin
            write_reg(CSR_FADE_TIME, pick_fade_time());
            write_reg(CSR_BRIGHTNESS, pick_brightness());
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            want = $urandom_range(0, 1);
            fast = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 6)
               send_item(OP_TICK, want, fast, PRED);
            else
               send_item(OP_REQUEST, want, fast, PRED);
         end
      end

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (err_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/ledfade_pkg.sv
hw/rtl/ledfade_req_if.sv
hw/rtl/ledfade_rsp_if.sv
hw/rtl/ledfade_csr_if.sv
hw/rtl/ledfade_div.sv
hw/rtl/led_on_off_fade_ramp.sv
verif/tb_led_on_off_fade_ramp.sv
